/* rtl/asb_pkg.sv */
// ----------------------------------------------------------------------------
// asb_pkg - shared types and constants of the adaptive spin backoff block
// Event codes, configuration register indexes, reset values and the structs
// that carry configuration, controller state and one result between modules.
// ----------------------------------------------------------------------------
package asb_pkg;

    localparam int unsigned CNT_W   = 10;   // spin counts, budgets, limits
    localparam int unsigned SLPC_W  = 11;   // sleep counter
    localparam int unsigned US_W    = 20;   // sleep lengths in microseconds
    localparam int unsigned CUR_W   = 21;   // current sleep with growth headroom
    localparam int unsigned ACT_W   = 3;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 20;
    localparam int unsigned FOLD_W  = 14;   // shared*15 + budget

    typedef enum logic [ACT_W-1:0] {
        ACT_BEGIN  = 3'd0,
        ACT_FAILED = 3'd1,
        ACT_ACQ    = 3'd2,
        ACT_LOAD   = 3'd3,
        ACT_FOLD   = 3'd4
    } asb_action_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SPIN_FLOOR    = 3'd0,
        CFG_SPIN_CEILING  = 3'd1,
        CFG_DELAY_LIMIT   = 3'd2,
        CFG_FIRST_SLEEP   = 3'd3,
        CFG_SLEEP_CEILING = 3'd4
    } asb_cfg_idx_t;

    localparam logic [CNT_W-1:0] RST_SPIN_FLOOR    = 10'd10;
    localparam logic [CNT_W-1:0] RST_SPIN_CEILING  = 10'd1000;
    localparam logic [CNT_W-1:0] RST_DELAY_LIMIT   = 10'd1000;
    localparam logic [US_W-1:0]  RST_FIRST_SLEEP   = 20'd1000;
    localparam logic [US_W-1:0]  RST_SLEEP_CEILING = 20'd1000000;
    localparam logic [CNT_W-1:0] RST_SPIN_BUDGET   = 10'd100;

    localparam logic [SLPC_W-1:0] BUDGET_STEP_UP   = 11'd100;
    localparam logic [CNT_W-1:0]  DELAY_COUNT_SAT  = 10'h3FF;

    typedef struct packed {
        logic [CNT_W-1:0] spin_floor;
        logic [CNT_W-1:0] spin_ceiling;
        logic [CNT_W-1:0] delay_limit;
        logic [US_W-1:0]  first_sleep_us;
        logic [US_W-1:0]  sleep_ceiling_us;
    } asb_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]  spin_count;
        logic [SLPC_W-1:0] sleep_count;
        logic [CUR_W-1:0]  current_sleep;
        logic [CNT_W-1:0]  spin_budget;
        logic              stuck_flag;
    } asb_state_t;

    typedef struct packed {
        logic [US_W-1:0]  sleep_us;
        logic             stuck;
        logic [CNT_W-1:0] delay_count;
        logic [CNT_W-1:0] spin_budget_now;
        logic [CNT_W-1:0] folded_estimate;
    } asb_result_t;

endpackage

/* rtl/asb_if.sv */
// ----------------------------------------------------------------------------
// asb_in_if / asb_out_if - request and result channels
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface asb_in_if #(
    parameter int unsigned RAND_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           action;
    logic [RAND_BITS-1:0] rand_fraction;
    logic [9:0]           shared_estimate;

    modport source (output valid, action, rand_fraction, shared_estimate, input ready);
    modport sink   (input valid, action, rand_fraction, shared_estimate, output ready);
endinterface

interface asb_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] sleep_us;
    logic        stuck;
    logic [9:0]  delay_count;
    logic [9:0]  spin_budget_now;
    logic [9:0]  folded_estimate;

    modport source (output valid, sleep_us, stuck, delay_count, spin_budget_now,
                    folded_estimate, input ready);
    modport sink   (input valid, sleep_us, stuck, delay_count, spin_budget_now,
                    folded_estimate, output ready);
endinterface

/* rtl/adaptive_spin_backoff_core.sv */
// ----------------------------------------------------------------------------
// adaptive_spin_backoff_core - backoff controller for lock acquisition
// Randomized exponential sleep backoff with an adaptive spin budget.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one event request per handshake: action (begin, attempt
//   failed, acquired, load estimate, fold estimate), a random growth
//   fraction and a shared budget estimate. out_ch returns exactly one result
//   per request, in order: sleep length, stuck flag, delay count, current
//   spin budget and the folded estimate.
//   A request is held in the input register; the event logic then updates
//   the controller state and loads the result register. Throughput is one
//   request per cycle while out_ch does not stall; the critical path is the
//   21 x RAND_BITS growth multiply feeding the ceiling compare.
//   When out_ch stalls, the result register holds and one more request is
//   still taken into the input register; ready drops only when both hold.
//   Reset restores the configuration defaults, clears the counters, current
//   sleep and stuck flag, sets the spin budget to 100 and empties both
//   registers. Write configuration (cfg_we/cfg_index/cfg_data) only while
//   no request is in flight.
// ----------------------------------------------------------------------------
module adaptive_spin_backoff_core #(
    parameter int unsigned RAND_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    asb_in_if.sink       in_ch,
    asb_out_if.source    out_ch,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [19:0]  cfg_data
);
    import asb_pkg::*;

    asb_cfg_t             cfg;

    // input register
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [ACT_W-1:0]     action_reg;
    logic [RAND_BITS-1:0] rand_reg;
    logic [CNT_W-1:0]     shared_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    asb_result_t          result_reg;
    asb_result_t          result_next;

    // controller state
    asb_state_t           state_reg;
    asb_state_t           state_next;

    logic                 in_take;
    logic                 advance;

    asb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asb_step #(
        .RAND_BITS (RAND_BITS)
    ) u_step (
        .cfg             (cfg),
        .state           (state_reg),
        .action          (action_reg),
        .rand_fraction   (rand_reg),
        .shared_estimate (shared_reg),
        .state_next      (state_next),
        .result          (result_next)
    );

    // Advance the held request when the result register is empty or draining.
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.spin_count    <= '0;
            state_reg.sleep_count   <= '0;
            state_reg.current_sleep <= '0;
            state_reg.spin_budget   <= RST_SPIN_BUDGET;
            state_reg.stuck_flag    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // commit state only when the request's result is captured
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= in_ch.action;
            rand_reg   <= in_ch.rand_fraction;
            shared_reg <= in_ch.shared_estimate;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.sleep_us        = result_reg.sleep_us;
    assign out_ch.stuck           = result_reg.stuck;
    assign out_ch.delay_count     = result_reg.delay_count;
    assign out_ch.spin_budget_now = result_reg.spin_budget_now;
    assign out_ch.folded_estimate = result_reg.folded_estimate;

endmodule

/* rtl/asb_cfg.sv */
// ----------------------------------------------------------------------------
// asb_cfg - configuration register file
// Five write-only registers, loaded by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module asb_cfg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [19:0]            cfg_data,
    output asb_pkg::asb_cfg_t      cfg
);
    import asb_pkg::*;

    asb_cfg_t cfg_reg;
    asb_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPIN_FLOOR:    cfg_next.spin_floor       = cfg_data[CNT_W-1:0];
                CFG_SPIN_CEILING:  cfg_next.spin_ceiling     = cfg_data[CNT_W-1:0];
                CFG_DELAY_LIMIT:   cfg_next.delay_limit      = cfg_data[CNT_W-1:0];
                CFG_FIRST_SLEEP:   cfg_next.first_sleep_us   = cfg_data[US_W-1:0];
                CFG_SLEEP_CEILING: cfg_next.sleep_ceiling_us = cfg_data[US_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spin_floor       <= RST_SPIN_FLOOR;
            cfg_reg.spin_ceiling     <= RST_SPIN_CEILING;
            cfg_reg.delay_limit      <= RST_DELAY_LIMIT;
            cfg_reg.first_sleep_us   <= RST_FIRST_SLEEP;
            cfg_reg.sleep_ceiling_us <= RST_SLEEP_CEILING;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/asb_grow.sv */
// ----------------------------------------------------------------------------
// asb_grow - randomized sleep growth
// Return cur + round(cur * r / 2^RAND_BITS), half up, wrapped to 21 bits.
// ----------------------------------------------------------------------------
module asb_grow #(
    parameter int unsigned RAND_BITS = 16
) (
    input  logic [20:0]          cur,
    input  logic [RAND_BITS-1:0] r,
    output logic [20:0]          grown
);
    import asb_pkg::*;

    localparam int unsigned PW = CUR_W + RAND_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (RAND_BITS - 1);

    logic [PW-1:0]    prod;
    logic [PW-1:0]    rounded;
    logic [CUR_W:0]   sum;

    assign prod    = PW'(cur) * PW'(r);
    assign rounded = prod + HALF;
    assign sum     = {1'b0, cur} + {1'b0, rounded[PW-1:RAND_BITS]};
    assign grown   = sum[CUR_W-1:0];

endmodule

/* rtl/asb_step.sv */
// ----------------------------------------------------------------------------
// asb_step - per-event next state and result
// Decode one event against the current controller state and configuration.
// ----------------------------------------------------------------------------
module asb_step #(
    parameter int unsigned RAND_BITS = 16
) (
    input  asb_pkg::asb_cfg_t    cfg,
    input  asb_pkg::asb_state_t  state,
    input  logic [2:0]           action,
    input  logic [RAND_BITS-1:0] rand_fraction,
    input  logic [9:0]           shared_estimate,
    output asb_pkg::asb_state_t  state_next,
    output asb_pkg::asb_result_t result
);
    import asb_pkg::*;

    logic [CNT_W-1:0]  spin_inc;
    logic [SLPC_W-1:0] sleep_inc;
    logic [CUR_W-1:0]  cur_base;
    logic [CUR_W-1:0]  grown;
    logic [SLPC_W-1:0] budget_up;
    logic [CNT_W-1:0]  budget_dn;
    logic [FOLD_W-1:0] fold_sum;
    logic [US_W-1:0]   sleep_now;
    logic [CNT_W-1:0]  folded;

    assign spin_inc  = state.spin_count + CNT_W'(1);
    assign sleep_inc = state.sleep_count + SLPC_W'(1);
    assign cur_base  = (state.current_sleep == '0) ? {1'b0, cfg.first_sleep_us}
                                                  : state.current_sleep;
    assign budget_up = {1'b0, state.spin_budget} + BUDGET_STEP_UP;
    assign budget_dn = state.spin_budget - CNT_W'(1);
    // shared*15 as shared*16 - shared
    assign fold_sum  = ({4'b0, shared_estimate} << 4) - {4'b0, shared_estimate}
                     + {4'b0, state.spin_budget};

    asb_grow #(
        .RAND_BITS (RAND_BITS)
    ) u_grow (
        .cur   (cur_base),
        .r     (rand_fraction),
        .grown (grown)
    );

    always_comb
    begin
        state_next = state;
        sleep_now  = '0;
        folded     = '0;
        unique case (action)
            ACT_BEGIN:
            begin
                state_next.spin_count    = '0;
                state_next.sleep_count   = '0;
                state_next.current_sleep = '0;
                state_next.stuck_flag    = 1'b0;
            end
            ACT_FAILED:
            begin
                if (!state.stuck_flag)
                begin
                    state_next.spin_count = spin_inc;
                    if (spin_inc >= state.spin_budget)
                    begin
                        state_next.sleep_count = sleep_inc;
                        if (sleep_inc > {1'b0, cfg.delay_limit})
                        begin
                            // freeze: keep current sleep and the raised spin count
                            state_next.stuck_flag = 1'b1;
                        end
                        else
                        begin
                            sleep_now             = cur_base[US_W-1:0];
                            state_next.spin_count = '0;
                            if (grown > {1'b0, cfg.sleep_ceiling_us})
                                state_next.current_sleep = {1'b0, cfg.first_sleep_us};
                            else
                                state_next.current_sleep = grown;
                        end
                    end
                end
            end
            ACT_ACQ:
            begin
                if (!state.stuck_flag)
                begin
                    if (state.current_sleep == '0)
                    begin
                        if (state.spin_budget < cfg.spin_ceiling)
                        begin
                            if (budget_up < {1'b0, cfg.spin_ceiling})
                                state_next.spin_budget = budget_up[CNT_W-1:0];
                            else
                                state_next.spin_budget = cfg.spin_ceiling;
                        end
                    end
                    else if (state.spin_budget > cfg.spin_floor)
                    begin
                        if (budget_dn > cfg.spin_floor)
                            state_next.spin_budget = budget_dn;
                        else
                            state_next.spin_budget = cfg.spin_floor;
                    end
                end
            end
            ACT_LOAD:
            begin
                state_next.spin_budget = shared_estimate;
            end
            ACT_FOLD:
            begin
                folded = fold_sum[FOLD_W-1:4];
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    always_comb
    begin
        result.sleep_us        = sleep_now;
        result.stuck           = state_next.stuck_flag;
        result.delay_count     = state_next.sleep_count[SLPC_W-1] ? DELAY_COUNT_SAT
                               : state_next.sleep_count[CNT_W-1:0];
        result.spin_budget_now = state_next.spin_budget;
        result.folded_estimate = folded;
    end

endmodule

/* rtl/asb_checker.sv */
// ----------------------------------------------------------------------------
// asb_checker - port-level checks of the backoff controller
// Watch the channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module asb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [19:0] sleep_us,
    input  logic        stuck,
    input  logic [9:0]  delay_count
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sleep_us))
        else $error("result dropped or changed while stalled");

    // accept a request whenever the result register is empty
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request blocked with empty result register");

    // a stuck controller never asks for a sleep
    a_stuck_no_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stuck |-> sleep_us == 20'd0)
        else $error("sleep issued while stuck");

    // a sleep always counts toward the delay count
    a_sleep_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sleep_us != 20'd0 |-> delay_count != 10'd0)
        else $error("sleep issued with zero delay count");

endmodule

bind adaptive_spin_backoff_core asb_checker u_asb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sleep_us    (out_ch.sleep_us),
    .stuck       (out_ch.stuck),
    .delay_count (out_ch.delay_count)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the adaptive spin backoff core
// Drives backoff event requests through the valid/ready request channel,
// mirrors the controller (spin count, sleep count, current sleep, spin budget,
// stuck flag) in a local predictor and checks every result field by field.
// Directed requests cover the estimate paths, sleep growth, wrap, stuck and
// zero cases; random acquisition sequences with noise follow, under several
// register settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import asb_pkg::*;

    localparam int unsigned RAND_BITS    = 16;
    localparam logic [RAND_BITS-1:0] FRAC_MAX = '1;
    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned SETTLE_CYCLES = 8;     // settle margin after the final drain
    localparam int unsigned PRINT_CAP    = 40;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_REQUESTS = 56;

    // Action codes outside the defined set; the block must report status only
    localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_MID   = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CDATA_W-1:0] cfg_data;

    asb_in_if #(.RAND_BITS(RAND_BITS)) req_ch ();
    asb_out_if                         res_ch ();

    adaptive_spin_backoff_core #(.RAND_BITS(RAND_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register mirror, controller mirror, expected results
    // ------------------------------------------------------------------------
    asb_cfg_t    cfg_mirror;
    asb_state_t  ctl;
    asb_result_t pending_backoff[$];

    int unsigned mismatch_count = 0;
    int unsigned requests_sent  = 0;
    int unsigned cycle_count    = 0;
    int unsigned stall_left     = 0;
    bit          steady_flow    = 1'b0;   // set: neither side idles

    function automatic asb_cfg_t make_cfg(input logic [CNT_W-1:0] spins_lo,
                                          input logic [CNT_W-1:0] spins_hi,
                                          input logic [CNT_W-1:0] sleeps_max,
                                          input logic [US_W-1:0]  first_us,
                                          input logic [US_W-1:0]  wrap_us);
        asb_cfg_t c;
        c.spin_floor       = spins_lo;
        c.spin_ceiling     = spins_hi;
        c.delay_limit      = sleeps_max;
        c.first_sleep_us   = first_us;
        c.sleep_ceiling_us = wrap_us;
        return c;
    endfunction

    // Advance the controller mirror by one event and return the result it owes.
    function automatic asb_result_t backoff_predict(input logic [ACT_W-1:0]     act,
                                                    input logic [RAND_BITS-1:0] frac,
                                                    input logic [CNT_W-1:0]     shared);
        asb_result_t res;
        logic [63:0] prod;
        logic [63:0] bump;
        logic [10:0] raised;
        int unsigned blend;
        res = '0;
        unique case (act)
            ACT_BEGIN:
            begin
                ctl.spin_count    = '0;
                ctl.sleep_count   = '0;
                ctl.current_sleep = '0;
                ctl.stuck_flag    = 1'b0;
            end
            ACT_FAILED:
            begin
                if (!ctl.stuck_flag)
                begin
                    ctl.spin_count = ctl.spin_count + 1'b1;
                    if (ctl.spin_count >= ctl.spin_budget)
                    begin
                        ctl.sleep_count = ctl.sleep_count + 1'b1;
                        // Past the limit: freeze, emit no sleep, keep spin count
                        if (ctl.sleep_count > cfg_mirror.delay_limit)
                            ctl.stuck_flag = 1'b1;
                        else
                        begin
                            if (ctl.current_sleep == '0)
                                ctl.current_sleep = {1'b0, cfg_mirror.first_sleep_us};
                            res.sleep_us = ctl.current_sleep[US_W-1:0];
                            // Grow by cur * frac / 2^RAND_BITS, rounded half up
                            prod = 64'(ctl.current_sleep) * 64'(frac);
                            bump = (prod + (64'd1 << (RAND_BITS - 1))) >> RAND_BITS;
                            ctl.current_sleep = CUR_W'(64'(ctl.current_sleep) + bump);
                            if (ctl.current_sleep > {1'b0, cfg_mirror.sleep_ceiling_us})
                                ctl.current_sleep = {1'b0, cfg_mirror.first_sleep_us};
                            ctl.spin_count = '0;
                        end
                    end
                end
            end
            ACT_ACQ:
            begin
                if (!ctl.stuck_flag)
                begin
                    if (ctl.current_sleep == '0)
                    begin
                        if (ctl.spin_budget < cfg_mirror.spin_ceiling)
                        begin
                            raised = {1'b0, ctl.spin_budget} + BUDGET_STEP_UP;
                            ctl.spin_budget = (raised < {1'b0, cfg_mirror.spin_ceiling})
                                            ? raised[CNT_W-1:0] : cfg_mirror.spin_ceiling;
                        end
                    end
                    else if (ctl.spin_budget > cfg_mirror.spin_floor)
                    begin
                        ctl.spin_budget = (ctl.spin_budget - 1'b1 > cfg_mirror.spin_floor)
                                        ? ctl.spin_budget - 1'b1 : cfg_mirror.spin_floor;
                    end
                end
            end
            ACT_LOAD:
                ctl.spin_budget = shared;
            ACT_FOLD:
            begin
                blend = shared * 15 + ctl.spin_budget;
                res.folded_estimate = CNT_W'(blend / 16);
            end
            default:
            begin
            end
        endcase
        res.stuck           = ctl.stuck_flag;
        res.delay_count     = (ctl.sleep_count > SLPC_W'(DELAY_COUNT_SAT))
                            ? DELAY_COUNT_SAT : ctl.sleep_count[CNT_W-1:0];
        res.spin_budget_now = ctl.spin_budget;
        return res;
    endfunction

    // Most gaps short, a few long
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Request side. Every task is entered and left at a rising edge, so each
    // signal gets at most one nonblocking write per time step.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [ACT_W-1:0]     act,
                                input logic [RAND_BITS-1:0] frac,
                                input logic [CNT_W-1:0]     shared);
        int unsigned gap;
        gap = steady_flow ? 0 : idle_length();
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.action          <= act;
        req_ch.rand_fraction   <= frac;
        req_ch.shared_estimate <= shared;
        // Hold the request until the block takes it
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_backoff.push_back(backoff_predict(act, frac, shared));
        requests_sent++;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_backoff.size() != 0);
    endtask

    // Write all five registers while the block is idle
    task automatic reconfigure(input asb_cfg_t c);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= CFG_SPIN_FLOOR;
        cfg_data  <= CDATA_W'(c.spin_floor);
        @(posedge clk);
        cfg_index <= CFG_SPIN_CEILING;
        cfg_data  <= CDATA_W'(c.spin_ceiling);
        @(posedge clk);
        cfg_index <= CFG_DELAY_LIMIT;
        cfg_data  <= CDATA_W'(c.delay_limit);
        @(posedge clk);
        cfg_index <= CFG_FIRST_SLEEP;
        cfg_data  <= c.first_sleep_us;
        @(posedge clk);
        cfg_index <= CFG_SLEEP_CEILING;
        cfg_data  <= c.sleep_ceiling_us;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_mirror = c;
        @(posedge clk);
    endtask

    function automatic logic [RAND_BITS-1:0] any_fraction();
        return RAND_BITS'($urandom());
    endfunction

    // Small budgets are what make sleeps, wraps and stuck states reachable
    function automatic logic [CNT_W-1:0] budget_pick();
        if ($urandom_range(0, 3) == 0)
            return CNT_W'($urandom_range(1, 1000));
        return CNT_W'($urandom_range(1, 6));
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Fold and load at the field extremes, plus the undefined action codes
    task automatic test_estimate_paths();
        send_request(ACT_FOLD, '0, 10'd1000);
        send_request(ACT_FOLD, '0, 10'd1);
        send_request(ACT_LOAD, '0, 10'd1000);
        send_request(ACT_FOLD, FRAC_MAX, 10'd1000);
        send_request(ACT_LOAD, '0, 10'd1);
        send_request(ACT_FOLD, '0, 10'd1);
        send_request(ACT_UNUSED_FIRST, FRAC_MAX, 10'h3FF);
        send_request(ACT_UNUSED_MID, '0, 10'd0);
        send_request(ACT_UNUSED_LAST, FRAC_MAX, 10'h3FF);
    endtask

    // One spin per sleep: growth at full and half fraction, wrap above the
    // ceiling, zero growth, then stuck past the limit, frozen, and cleared
    task automatic test_growth_and_stuck();
        reconfigure(make_cfg(10'd1, 10'd1000, 10'd3, 20'd1000, 20'd2500));
        send_request(ACT_BEGIN, '0, 10'd1);
        send_request(ACT_LOAD, '0, 10'd1);
        send_request(ACT_FAILED, FRAC_MAX, 10'd1);
        send_request(ACT_FAILED, RAND_BITS'(1 << (RAND_BITS - 1)), 10'd1);
        send_request(ACT_FAILED, '0, 10'd1);
        send_request(ACT_FAILED, RAND_BITS'(100), 10'd1);
        send_request(ACT_FAILED, FRAC_MAX, 10'd1);
        send_request(ACT_ACQ, '0, 10'd1);
        send_request(ACT_FOLD, '0, 10'd500);
        send_request(ACT_BEGIN, '0, 10'd1);
        send_request(ACT_ACQ, '0, 10'd1);
    endtask

    // Zero spin budget sleeps on every failure; zero first sleep emits zero
    // and leaves the acquisition counted as one without a sleep
    task automatic test_zero_budget_and_sleep();
        reconfigure(make_cfg(10'd1, 10'd1000, 10'd1000, 20'd0, 20'd1000000));
        send_request(ACT_BEGIN, '0, 10'd1);
        send_request(ACT_LOAD, '0, 10'd0);
        send_request(ACT_FAILED, FRAC_MAX, 10'd1);
        send_request(ACT_FAILED, '0, 10'd1);
        send_request(ACT_ACQ, '0, 10'd1);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    // One lock acquisition: begin, maybe a budget load, a run of failures with
    // the odd fold mixed in, and usually the acquire at the end
    task automatic run_acquisition();
        int unsigned fails;
        send_request(ACT_BEGIN, any_fraction(), CNT_W'($urandom_range(1, 1000)));
        if ($urandom_range(0, 2) == 0)
            send_request(ACT_LOAD, any_fraction(), budget_pick());
        fails = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 60);
        repeat (fails)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(ACT_FOLD, any_fraction(), CNT_W'($urandom_range(1, 1000)));
            send_request(ACT_FAILED, any_fraction(), CNT_W'($urandom_range(1, 1000)));
        end
        if ($urandom_range(0, 99) < 85)
            send_request(ACT_ACQ, any_fraction(), CNT_W'($urandom_range(1, 1000)));
    endtask

    function automatic asb_cfg_t phase_cfg(input int unsigned phase);
        unique case (phase)
            0: return make_cfg(RST_SPIN_FLOOR, RST_SPIN_CEILING, RST_DELAY_LIMIT,
                               RST_FIRST_SLEEP, RST_SLEEP_CEILING);
            1: return make_cfg(10'd1, 10'd1, 10'd1, 20'd1, 20'd1);
            2: return make_cfg(10'd1000, 10'd1000, 10'd1000, 20'd1000000, 20'd1000000);
            default:
                return make_cfg(CNT_W'($urandom_range(1, 1000)),
                                CNT_W'($urandom_range(1, 1000)),
                                CNT_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                                                   : $urandom_range(1, 1000)),
                                US_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 5000)
                                                                  : $urandom_range(1, 1000000)),
                                US_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 20000)
                                                                  : $urandom_range(1, 1000000)));
        endcase
    endfunction

    // Phases of well-formed acquisitions with noise and occasional full
    // drains; one phase runs with no idling on either side
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned roll;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            reconfigure(phase_cfg(phase));
            steady_flow = (phase == 3);
            goal = requests_sent + PHASE_REQUESTS;
            while (requests_sent < goal)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    run_acquisition();
                else if (roll < 95)
                    send_request(ACT_W'($urandom_range(0, 7)), any_fraction(),
                                 CNT_W'($urandom_range(1, 1000)));
                else
                    drain_results();
            end
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure and field-by-field compare against the
    // oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        asb_result_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_backoff.size() == 0)
                    report_mismatch($sformatf("result with no request pending (sleep_us %0d)",
                                              res_ch.sleep_us));
                else
                begin
                    want = pending_backoff.pop_front();
                    if (res_ch.sleep_us !== want.sleep_us)
                        report_mismatch($sformatf("sleep_us expected %0d got %0d",
                                                  want.sleep_us, res_ch.sleep_us));
                    if (res_ch.stuck !== want.stuck)
                        report_mismatch($sformatf("stuck expected %0d got %0d",
                                                  want.stuck, res_ch.stuck));
                    if (res_ch.delay_count !== want.delay_count)
                        report_mismatch($sformatf("delay_count expected %0d got %0d",
                                                  want.delay_count, res_ch.delay_count));
                    if (res_ch.spin_budget_now !== want.spin_budget_now)
                        report_mismatch($sformatf("spin_budget_now expected %0d got %0d",
                                                  want.spin_budget_now, res_ch.spin_budget_now));
                    if (res_ch.folded_estimate !== want.folded_estimate)
                        report_mismatch($sformatf("folded_estimate expected %0d got %0d",
                                                  want.folded_estimate, res_ch.folded_estimate));
                end
            end
            // Pick a new stall now and then; hold ready low while it runs
            if (stall_left == 0 && !steady_flow && $urandom_range(0, 99) < 30)
                stall_left = idle_length();
            if (stall_left != 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
        else
            res_ch.ready <= 1'b0;
    end

    // Watchdog: end the run if it never reaches its normal end
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        // Known values on every input from time zero
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_SPIN_FLOOR;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.action          = ACT_BEGIN;
        req_ch.rand_fraction   = '0;
        req_ch.shared_estimate = '0;

        cfg_mirror = make_cfg(RST_SPIN_FLOOR, RST_SPIN_CEILING, RST_DELAY_LIMIT,
                              RST_FIRST_SLEEP, RST_SLEEP_CEILING);
        ctl = '0;
        ctl.spin_budget = RST_SPIN_BUDGET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_estimate_paths();
        test_growth_and_stuck();
        test_zero_budget_and_sleep();
        test_random_traffic();

        // Wait out the last results, then a few cycles for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
